[rtl/shell_command_tokenizer_defines.svh]
// ----------------------------------------------------------------------------
// Shell command tokenizer assertion macros
// Shared concurrent checks, clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef SHELL_COMMAND_TOKENIZER_DEFINES_SVH
`define SHELL_COMMAND_TOKENIZER_DEFINES_SVH

// Same-cycle implication.
`define SCT_CHECK(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sct check failed");

// Next-cycle implication.
`define SCT_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sct next-cycle check failed");

`endif

[rtl/sct_pkg.sv]
// ----------------------------------------------------------------------------
// sct_pkg
// Types, codes and result builders shared by the tokenizer modules.
// ----------------------------------------------------------------------------
package sct_pkg;

  localparam int MAX_TOKENS_DEF   = 32;
  localparam int BUFFER_BYTES_DEF = 256;
  localparam int QUEUE_DEPTH_DEF  = 2;
  localparam int MAX_RESULTS      = 5;

  // result kinds
  localparam logic [1:0] KIND_BYTE   = 2'd0;
  localparam logic [1:0] KIND_RECORD = 2'd1;
  localparam logic [1:0] KIND_FINISH = 2'd2;

  // token kinds
  localparam logic [2:0] TOK_AMP  = 3'd0;
  localparam logic [2:0] TOK_PIPE = 3'd1;
  localparam logic [2:0] TOK_LESS = 3'd2;
  localparam logic [2:0] TOK_GT   = 3'd3;
  localparam logic [2:0] TOK_WORD = 3'd4;

  // error codes
  localparam logic [2:0] ERR_NONE  = 3'd0;
  localparam logic [2:0] ERR_MANY  = 3'd1;
  localparam logic [2:0] ERR_QUOTE = 3'd2;
  localparam logic [2:0] ERR_ADJ   = 3'd3;
  localparam logic [2:0] ERR_OVF   = 3'd4;

  // characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_LESS  = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_PIPE  = 8'h7C;

  typedef struct packed {
    logic [2:0] error_code;
    logic [5:0] token_total;
    logic [2:0] token_kind;
    logic [7:0] token_start;
    logic [4:0] token_number;
    logic [7:0] byte_index;
    logic [7:0] byte_value;
    logic [1:0] kind;
  } result_t;

  // all results caused by one character
  typedef struct packed {
    result_t [MAX_RESULTS-1:0] res;
    logic [2:0]                cnt;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic result_t mk_byte(input logic [7:0] v, input logic [7:0] idx);
    result_t r;
    r            = '0;
    r.kind       = KIND_BYTE;
    r.byte_value = v;
    r.byte_index = idx;
    return r;
  endfunction

  function automatic result_t mk_record(input logic [4:0] num, input logic [7:0] start,
                                        input logic [2:0] tk);
    result_t r;
    r              = '0;
    r.kind         = KIND_RECORD;
    r.token_number = num;
    r.token_start  = start;
    r.token_kind   = tk;
    return r;
  endfunction

  function automatic result_t mk_finish(input logic [5:0] total, input logic [2:0] code);
    result_t r;
    r             = '0;
    r.kind        = KIND_FINISH;
    r.token_total = total;
    r.error_code  = code;
    return r;
  endfunction

endpackage

[rtl/shell_command_tokenizer.sv]
// A character's results are registered in the bundle queue before they are offered on m_*.
// Throughput: one character per cycle while the bundle queue is not full; a character
//   with k results holds the emitter for k transactions (up to five), absorbed by the bundle queue.
// Characters that yield no result (blanks between tokens, discarded bytes) are never queued.
// Reset: synchronous rst clears lexer state, queue pointers and emitter index at once.
// ----------------------------------------------------------------------------
// shell_command_tokenizer
// Streaming shell lexer: characters in, buffer bytes, token records and line status out.
// ----------------------------------------------------------------------------
module shell_command_tokenizer import sct_pkg::*; #(
  parameter int MAX_TOKENS   = MAX_TOKENS_DEF,
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_in
  output logic        m_tvalid,
  input  logic        m_tready,
  // [7:0] byte_value, [15:8] byte_index, [20:16] token_number, [28:21] token_start,
  // [31:29] token_kind, [37:32] token_total, [40:38] error_code, [47:41] zero
  output logic [47:0] m_tdata,
  output logic [1:0]  m_tuser,   // [1:0] kind
  output logic        m_tlast    // last result of this character
);

  // Front end: one character per cycle, all its results built in one bundle.
  // The queue holds bundles, so a multi-result character never stalls the lexer
  // until the queue fills up.
  logic      accept;
  logic      push;
  logic      pop;
  bundle_t   push_data;
  bundle_t   head;
  q_status_t q_status;

  assign s_tready = !q_status.full;
  assign accept   = s_tvalid && s_tready;

  sct_front #(
    .MAX_TOKENS   (MAX_TOKENS),
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .char_in (s_tdata),
    .push    (push),
    .bundle  (push_data)
  );

  // bundle queue: parts the input side from the result side
  sct_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  // back end: one result transaction per cycle from the head bundle while m_tready is high
  sct_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .status   (q_status),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

[rtl/sct_front.sv]
// ----------------------------------------------------------------------------
// sct_front
// Lexer state and character classification; builds each character's results.
// ----------------------------------------------------------------------------
module sct_front import sct_pkg::*; #(
  parameter int MAX_TOKENS   = MAX_TOKENS_DEF,
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] char_in,
  output logic       push,
  output bundle_t    bundle
);

  localparam int WPW = $clog2(BUFFER_BYTES + 1);
  localparam int TCW = $clog2(MAX_TOKENS + 1);
  localparam logic [WPW-1:0] BUF_LIMIT = WPW'(BUFFER_BYTES);
  localparam logic [TCW-1:0] TOK_LIMIT = TCW'(MAX_TOKENS);

  typedef enum logic [2:0] {
    PH_CHECK, PH_SKIP, PH_WORD, PH_QUOTE, PH_ERR_MANY, PH_ERR_ADJ, PH_ERR_OVF
  } phase_t;

  phase_t         phase, phase_next;
  logic           quote_dbl, quote_dbl_next;
  logic [TCW-1:0] tok_count, tok_count_next;
  logic [WPW-1:0] wr_pos, wr_pos_next;
  logic [7:0]     cur_start, cur_start_next;

  always_comb begin
    logic       is_end, is_blank, is_quote, is_op, do_check, do_begin, fin;
    logic [2:0] fin_code, n, tk;
    logic [7:0] close_ch;
    result_t [MAX_RESULTS-1:0] res;

    is_end   = (char_in == CH_LF) || (char_in == CH_NUL);
    is_blank = (char_in == CH_SPACE) || (char_in == CH_TAB);
    is_quote = (char_in == CH_SQ) || (char_in == CH_DQ);
    is_op    = (char_in == CH_AMP) || (char_in == CH_PIPE) ||
               (char_in == CH_LESS) || (char_in == CH_GT);
    close_ch = quote_dbl ? CH_DQ : CH_SQ;

    priority if (char_in == CH_AMP)  tk = TOK_AMP;
    else if (char_in == CH_PIPE)     tk = TOK_PIPE;
    else if (char_in == CH_LESS)     tk = TOK_LESS;
    else                             tk = TOK_GT;

    phase_next     = phase;
    quote_dbl_next = quote_dbl;
    tok_count_next = tok_count;
    wr_pos_next    = wr_pos;
    cur_start_next = cur_start;
    do_check       = 1'b0;
    do_begin       = 1'b0;
    fin            = 1'b0;
    fin_code       = ERR_NONE;
    n              = 3'd0;
    res            = '0;

    unique case (phase)
      PH_SKIP: begin
        if (is_end) fin = 1'b1;
        else        do_begin = 1'b1;
      end
      PH_WORD: begin
        if (is_end || is_blank || char_in == CH_AMP || char_in == CH_PIPE) begin
          if (wr_pos_next >= BUF_LIMIT) begin
            if (is_end) begin
              fin      = 1'b1;
              fin_code = ERR_OVF;
            end else begin
              phase_next = PH_ERR_OVF;
            end
          end else begin
            res[n]         = mk_byte(CH_NUL, 8'(wr_pos_next));
            n              = n + 3'd1;
            wr_pos_next    = wr_pos_next + 1'b1;
            res[n]         = mk_record(5'(tok_count_next), cur_start_next, TOK_WORD);
            n              = n + 3'd1;
            tok_count_next = tok_count_next + 1'b1;
            do_check       = 1'b1;
          end
        end else if (is_quote || char_in == CH_LESS || char_in == CH_GT) begin
          phase_next = PH_ERR_ADJ;
        end else if (wr_pos_next >= BUF_LIMIT) begin
          phase_next = PH_ERR_OVF;
        end else begin
          res[n]      = mk_byte(char_in, 8'(wr_pos_next));
          n           = n + 3'd1;
          wr_pos_next = wr_pos_next + 1'b1;
        end
      end
      PH_QUOTE: begin
        if (char_in == close_ch) begin
          if (wr_pos_next >= BUF_LIMIT) begin
            phase_next = PH_ERR_OVF;
          end else begin
            res[n]         = mk_byte(CH_NUL, 8'(wr_pos_next));
            n              = n + 3'd1;
            wr_pos_next    = wr_pos_next + 1'b1;
            res[n]         = mk_record(5'(tok_count_next), cur_start_next, TOK_WORD);
            n              = n + 3'd1;
            tok_count_next = tok_count_next + 1'b1;
            phase_next     = PH_CHECK;
          end
        end else if (is_end) begin
          fin      = 1'b1;
          fin_code = ERR_QUOTE;
        end else if (wr_pos_next >= BUF_LIMIT) begin
          phase_next = PH_ERR_OVF;
        end else begin
          res[n]      = mk_byte(char_in, 8'(wr_pos_next));
          n           = n + 3'd1;
          wr_pos_next = wr_pos_next + 1'b1;
        end
      end
      PH_ERR_MANY: begin
        fin      = is_end;
        fin_code = ERR_MANY;
      end
      PH_ERR_ADJ: begin
        fin      = is_end;
        fin_code = ERR_ADJ;
      end
      PH_ERR_OVF: begin
        fin      = is_end;
        fin_code = ERR_OVF;
      end
      default: do_check = 1'b1;
    endcase

    // between tokens: end of line, count check, then start of a token
    if (do_check) begin
      if (is_end)                          fin = 1'b1;
      else if (tok_count_next >= TOK_LIMIT) phase_next = PH_ERR_MANY;
      else                                 do_begin = 1'b1;
    end

    if (do_begin) begin
      if (is_blank) begin
        phase_next = PH_SKIP;
      end else begin
        cur_start_next = 8'(wr_pos_next);
        if (is_op) begin
          if (wr_pos_next >= BUF_LIMIT) begin
            phase_next = PH_ERR_OVF;
          end else begin
            res[n]      = mk_byte(char_in, 8'(wr_pos_next));
            n           = n + 3'd1;
            wr_pos_next = wr_pos_next + 1'b1;
            if (wr_pos_next >= BUF_LIMIT) begin
              phase_next = PH_ERR_OVF;
            end else begin
              res[n]         = mk_byte(CH_NUL, 8'(wr_pos_next));
              n              = n + 3'd1;
              wr_pos_next    = wr_pos_next + 1'b1;
              res[n]         = mk_record(5'(tok_count_next), cur_start_next, tk);
              n              = n + 3'd1;
              tok_count_next = tok_count_next + 1'b1;
              phase_next     = PH_CHECK;
            end
          end
        end else if (is_quote) begin
          quote_dbl_next = (char_in == CH_DQ);
          phase_next     = PH_QUOTE;
        end else if (wr_pos_next >= BUF_LIMIT) begin
          phase_next = PH_ERR_OVF;
        end else begin
          res[n]      = mk_byte(char_in, 8'(wr_pos_next));
          n           = n + 3'd1;
          wr_pos_next = wr_pos_next + 1'b1;
          phase_next  = PH_WORD;
        end
      end
    end

    // line finished: report and start a fresh line
    if (fin) begin
      res[n] = mk_finish((fin_code == ERR_NONE) ? 6'(tok_count_next) : 6'd0, fin_code);
      n              = n + 3'd1;
      phase_next     = PH_CHECK;
      quote_dbl_next = 1'b0;
      tok_count_next = '0;
      wr_pos_next    = '0;
      cur_start_next = '0;
    end

    bundle.res = res;
    bundle.cnt = n;
    push       = accept && (n != 3'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_CHECK;
      quote_dbl <= 1'b0;
      tok_count <= '0;
      wr_pos    <= '0;
      cur_start <= '0;
    end else if (accept) begin
      phase     <= phase_next;
      quote_dbl <= quote_dbl_next;
      tok_count <= tok_count_next;
      wr_pos    <= wr_pos_next;
      cur_start <= cur_start_next;
    end
  end

endmodule

[rtl/sct_queue.sv]
// ----------------------------------------------------------------------------
// sct_queue
// Short register queue of result bundles between lexer and emitter.
// ----------------------------------------------------------------------------
module sct_queue import sct_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  bundle_t   push_data,
  input  logic      pop,
  output bundle_t   head,
  output q_status_t status
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(QUEUE_DEPTH);

  bundle_t       mem [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign head         = mem[rd_ptr];
  assign status.full  = (count == FULL_CNT);
  assign status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

[rtl/sct_back.sv]
// ----------------------------------------------------------------------------
// sct_back
// Emitter: hands out the results of the head bundle one transaction each.
// ----------------------------------------------------------------------------
`include "shell_command_tokenizer_defines.svh"

module sct_back import sct_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  bundle_t     head,
  input  q_status_t   status,
  output logic        pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,
  output logic [1:0]  m_tuser,
  output logic        m_tlast
);

  logic [2:0] idx;
  result_t    cur;

  assign cur      = head.res[idx];
  assign m_tvalid = !status.empty;
  assign m_tlast  = (idx == head.cnt - 3'd1);
  assign m_tuser  = cur.kind;
  assign m_tdata  = {7'd0, cur.error_code, cur.token_total, cur.token_kind,
                     cur.token_start, cur.token_number, cur.byte_index, cur.byte_value};
  assign pop      = m_tvalid && m_tready && m_tlast;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (m_tvalid && m_tready) begin
      idx <= m_tlast ? 3'd0 : idx + 3'd1;
    end
  end

  `SCT_CHECK(a_head_not_empty, m_tvalid, head.cnt != 3'd0)
  `SCT_CHECK(a_idx_in_bundle, m_tvalid, idx < head.cnt)
  `SCT_CHECK(a_finish_is_last, m_tvalid && m_tuser == KIND_FINISH, m_tlast)
  `SCT_CHECK_NEXT(a_idx_rewinds, m_tvalid && m_tready && m_tlast, idx == 3'd0)

endmodule
